/* sv/limit_order_book_matcher_unit_macros.svh */
// Assertion macros for the order book matcher checker.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define LOBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LOBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lobm_pkg.sv */
// Shared types and codes of the order book matcher.
package lobm_pkg;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_MATCH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_REJECTED = 2'd1,
		ST_TRADE    = 2'd2,
		ST_NO_CROSS = 2'd3
	} status_t;

	localparam int unsigned SIDE_BUY  = 0;
	localparam int unsigned SIDE_SELL = 1;

	// Classified command passed from front to back.
	typedef struct packed {
		cmd_t        cmd;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
		logic [63:0] order_id;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] buy_id;
		logic [63:0] sell_id;
		logic [31:0] bid_px;
		logic [31:0] ask_px;
		logic [31:0] exe_px;
		logic [31:0] trade_qty;
	} result_t;

endpackage

/* sv/lobm_front.sv */
// Front end: takes input beats, decodes them and queues them for the back end.
module lobm_front import lobm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         busy_clear,
	output logic         q_valid,
	input  logic         q_ready,
	output item_t        q_item
);

	item_t      mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	item_t      dec;

	always_comb begin
		dec.cmd      = cmd_t'(s_tuser[0]);
		dec.side     = s_tuser[1];
		dec.price    = s_tdata[31:0];
		dec.qty      = s_tdata[63:32];
		dec.order_id = s_tdata[127:64];
	end

	assign s_tready = !busy_clear && (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* sv/lobm_back.sv */
// Back end: level tables, order slot store and the command sequencer.
module lobm_back import lobm_pkg::*; #(
	parameter int unsigned LEVELS_PER_SIDE = 16,
	parameter int unsigned ORDER_SLOTS     = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_ready,
	input  item_t        q_item,
	output logic         busy_clear,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata,
	output logic [1:0]   m_tuser
);

	localparam int unsigned CW = $clog2(LEVELS_PER_SIDE + 1);
	localparam int unsigned LW = $clog2(LEVELS_PER_SIDE);
	localparam int unsigned SW = $clog2(ORDER_SLOTS);
	localparam int unsigned UW = $clog2(ORDER_SLOTS + 1);

	typedef enum logic [11:0] {
		S_CLR   = 12'b000000000001,
		S_IDLE  = 12'b000000000010,
		S_SRCH  = 12'b000000000100,
		S_ALLOC = 12'b000000001000,
		S_ADDW  = 12'b000000010000,
		S_M0    = 12'b000000100000,
		S_M1    = 12'b000001000000,
		S_M2    = 12'b000010000000,
		S_M3    = 12'b000100000000,
		S_M4    = 12'b001000000000,
		S_M5    = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t state_q;

	// level tables, index 0 is the best level of each side
	logic [31:0]   lp_q  [2][LEVELS_PER_SIDE];
	logic [31:0]   lt_q  [2][LEVELS_PER_SIDE];
	logic [SW-1:0] lh_q  [2][LEVELS_PER_SIDE];
	logic [SW-1:0] ltl_q [2][LEVELS_PER_SIDE];
	logic [CW-1:0] cnt_q [2];

	// slot store
	logic [63:0]   id_mem   [ORDER_SLOTS];
	logic [31:0]   qty_mem  [ORDER_SLOTS];
	logic [SW-1:0] next_mem [ORDER_SLOTS];
	logic [63:0]   id_rd_q;
	logic [31:0]   qty_rd_q;
	logic [SW-1:0] next_rd_q;

	logic [SW-1:0] free_head_q, clr_q;
	logic [UW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic          found_q;
	item_t         itm_q;
	logic [SW-1:0] bs_q, as_q;
	logic [31:0]   bq_q, aq_q, t_q;
	logic          bz_q, az_q;
	result_t       res_q, out_q;
	logic          m_tvalid_q;

	logic          sd;
	logic [CW-1:0] n;
	logic [LW-1:0] ix;
	logic [31:0]   pcur;
	logic          srch_hit, srch_stop;
	logic          full_rej;
	logic [SW-1:0] qra, nra, nwa, nwd;
	logic          nwe, qwe, iwe;
	logic [SW-1:0] qwa;
	logic [31:0]   qwd;
	logic [31:0]   tmin;

	assign sd        = itm_q.side;
	assign n         = cnt_q[sd];
	assign ix        = idx_q[LW-1:0];
	assign pcur      = lp_q[sd][ix];
	assign srch_hit  = (pcur == itm_q.price);
	assign srch_stop = (sd == 1'(SIDE_BUY)) ? (itm_q.price > pcur) : (itm_q.price < pcur);
	assign full_rej  = (used_q >= UW'(ORDER_SLOTS)) ||
	                   (!found_q && (n >= CW'(LEVELS_PER_SIDE)));
	assign tmin      = (bq_q < qty_rd_q) ? bq_q : qty_rd_q;
	assign q_ready   = (state_q == S_IDLE);
	assign busy_clear = (state_q == S_CLR);

	// memory address and write control
	always_comb begin
		qra = lh_q[SIDE_BUY][0];
		nra = free_head_q;
		nwe = 1'b0;
		nwa = clr_q;
		nwd = (clr_q == SW'(ORDER_SLOTS - 1)) ? '0 : clr_q + 1'b1;
		qwe = 1'b0;
		iwe = 1'b0;
		qwa = free_head_q;
		qwd = itm_q.qty;
		case (state_q)
			S_CLR: begin
				nwe = 1'b1;
			end
			S_M1: begin
				qra = as_q;
			end
			S_M3: begin
				nra = bs_q;
				qwe = 1'b1;
				qwa = bs_q;
				qwd = bq_q - t_q;
			end
			S_ADDW: begin
				qwe = 1'b1;
				iwe = 1'b1;
				if (found_q) begin
					nwe = 1'b1;
					nwa = ltl_q[sd][ix];
					nwd = free_head_q;
				end
			end
			S_M4: begin
				nra = as_q;
				qwe = 1'b1;
				qwa = as_q;
				qwd = aq_q - t_q;
				nwe = bz_q;
				nwa = bs_q;
				nwd = free_head_q;
			end
			S_M5: begin
				nwe = az_q;
				nwa = as_q;
				nwd = free_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (nwe) begin
			next_mem[nwa] <= nwd;
		end
		if (qwe) begin
			qty_mem[qwa] <= qwd;
		end
		if (iwe) begin
			id_mem[free_head_q] <= itm_q.order_id;
		end
		next_rd_q <= next_mem[nra];
		qty_rd_q  <= qty_mem[qra];
		id_rd_q   <= id_mem[qra];
	end

	// level tables and per-item working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				itm_q <= q_item;
				res_q <= '0;
			end
			S_ALLOC: begin
				res_q.status <= full_rej ? ST_REJECTED : ST_ACCEPTED;
			end
			S_ADDW: begin
				if (found_q) begin
					lt_q[sd][ix]  <= lt_q[sd][ix] + itm_q.qty;
					ltl_q[sd][ix] <= free_head_q;
				end else begin
					for (int j = 1; j < LEVELS_PER_SIDE; j++) begin
						if (j > int'(ix)) begin
							lp_q[sd][j]  <= lp_q[sd][j-1];
							lt_q[sd][j]  <= lt_q[sd][j-1];
							lh_q[sd][j]  <= lh_q[sd][j-1];
							ltl_q[sd][j] <= ltl_q[sd][j-1];
						end
					end
					lp_q[sd][ix]  <= itm_q.price;
					lt_q[sd][ix]  <= itm_q.qty;
					lh_q[sd][ix]  <= free_head_q;
					ltl_q[sd][ix] <= free_head_q;
				end
			end
			S_M0: begin
				bs_q <= lh_q[SIDE_BUY][0];
				as_q <= lh_q[SIDE_SELL][0];
				if (cnt_q[SIDE_BUY] == '0 || cnt_q[SIDE_SELL] == '0 ||
				    lp_q[SIDE_BUY][0] < lp_q[SIDE_SELL][0]) begin
					res_q.status <= ST_NO_CROSS;
				end
			end
			S_M1: begin
				bq_q <= qty_rd_q;
				res_q.buy_id <= id_rd_q;
			end
			S_M2: begin
				aq_q <= qty_rd_q;
				t_q  <= tmin;
				bz_q <= (bq_q == tmin);
				az_q <= (qty_rd_q == tmin);
				res_q.sell_id <= id_rd_q;
			end
			S_M3: begin
				lt_q[SIDE_BUY][0]  <= lt_q[SIDE_BUY][0] - t_q;
				lt_q[SIDE_SELL][0] <= lt_q[SIDE_SELL][0] - t_q;
				res_q.status    <= ST_TRADE;
				res_q.bid_px    <= lp_q[SIDE_BUY][0];
				res_q.ask_px    <= lp_q[SIDE_SELL][0];
				res_q.exe_px    <= lp_q[SIDE_SELL][0];
				res_q.trade_qty <= t_q;
			end
			S_M4, S_M5: begin
				if ((state_q == S_M4) ? bz_q : az_q) begin
					if (((state_q == S_M4) ? bs_q : as_q) ==
					    ltl_q[(state_q == S_M5)][0]) begin
						for (int j = 0; j + 1 < LEVELS_PER_SIDE; j++) begin
							lp_q[(state_q == S_M5)][j]  <= lp_q[(state_q == S_M5)][j+1];
							lt_q[(state_q == S_M5)][j]  <= lt_q[(state_q == S_M5)][j+1];
							lh_q[(state_q == S_M5)][j]  <= lh_q[(state_q == S_M5)][j+1];
							ltl_q[(state_q == S_M5)][j] <= ltl_q[(state_q == S_M5)][j+1];
						end
					end else begin
						lh_q[(state_q == S_M5)][0] <= next_rd_q;
					end
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
			out_q <= res_q;
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			free_head_q <= '0;
			used_q      <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(ORDER_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (q_valid) begin
						state_q <= (q_item.cmd == CMD_MATCH) ? S_M0 : S_SRCH;
					end
				end
				S_SRCH: begin
					if (idx_q < n) begin
						if (srch_hit) begin
							found_q <= 1'b1;
							state_q <= S_ALLOC;
						end else if (srch_stop) begin
							state_q <= S_ALLOC;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						state_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					state_q <= full_rej ? S_DONE : S_ADDW;
				end
				S_ADDW: begin
					free_head_q <= next_rd_q;
					used_q      <= used_q + 1'b1;
					if (!found_q) begin
						cnt_q[sd] <= n + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_M0: begin
					if (cnt_q[SIDE_BUY] == '0 || cnt_q[SIDE_SELL] == '0 ||
					    lp_q[SIDE_BUY][0] < lp_q[SIDE_SELL][0]) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: begin
					if (bz_q) begin
						free_head_q <= bs_q;
						if (used_q != '0) begin
							used_q <= used_q - 1'b1;
						end
						if (bs_q == ltl_q[SIDE_BUY][0]) begin
							cnt_q[SIDE_BUY] <= cnt_q[SIDE_BUY] - 1'b1;
						end
					end
					state_q <= S_M5;
				end
				S_M5: begin
					if (az_q) begin
						free_head_q <= as_q;
						if (used_q != '0) begin
							used_q <= used_q - 1'b1;
						end
						if (as_q == ltl_q[SIDE_SELL][0]) begin
							cnt_q[SIDE_SELL] <= cnt_q[SIDE_SELL] - 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {out_q.trade_qty, out_q.exe_px, out_q.ask_px,
	                   out_q.bid_px, out_q.sell_id, out_q.buy_id};

endmodule

/* sv/limit_order_book_matcher_unit.sv */
// Top level of the limit order book matcher.
// Price-time priority order book: an add beat places an order at the tail of its price
// level (bids kept best-highest first, asks best-lowest first, new levels inserted in
// order); a match beat trades the smaller head quantity of best bid and best ask at the
// ask price when they cross. Every input beat yields exactly one result beat. A front end
// decodes beats into a two-entry queue, so input is taken while the back end works or a
// result waits on the output register. The back end runs one command at a time: an add
// searches the sorted levels in turn, then writes its slot; a crossing match steps through
// its states in turn, as the slot store has a single read port (both head orders are
// fetched and both freed slots relinked in turn); a no-cross match ends after the cross
// check. After reset the free-slot list is built by a pass over all ORDER_SLOTS slots,
// during which s_tready stays low. Adds beyond ORDER_SLOTS orders, or needing a new
// level on a side with LEVELS_PER_SIDE levels, are rejected; level totals wrap at 32 bits.
module limit_order_book_matcher_unit import lobm_pkg::*; #(
	parameter int unsigned LEVELS_PER_SIDE = 16,
	parameter int unsigned ORDER_SLOTS     = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // price[31:0], qty[63:32], order_id[127:64]
	input  logic [1:0]   s_tuser,  // command[0], side[1]
	output logic         m_tvalid,
	input  logic         m_tready,
	// buy_id[63:0], sell_id[127:64], bid price[159:128], ask price[191:160],
	// execution price[223:192], trade_qty[255:224]
	output logic [255:0] m_tdata,
	output logic [1:0]   m_tuser   // status[1:0]
);

	logic  q_valid, q_ready, busy_clear;
	item_t q_item;

	// decode and queue
	lobm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.busy_clear (busy_clear),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item)
	);

	// book state and command execution
	lobm_back #(
		.LEVELS_PER_SIDE (LEVELS_PER_SIDE),
		.ORDER_SLOTS     (ORDER_SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item),
		.busy_clear (busy_clear),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

/* sv/lobm_checker.sv */
// Port-level checker for the order book matcher, bound to the top level.
`include "limit_order_book_matcher_unit_macros.svh"

module lobm_checker import lobm_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [255:0] m_tdata,
	input logic [1:0]   m_tuser
);

	`LOBM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped")
	`LOBM_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`LOBM_ASSERT_NOW(a_quiet_fields, m_tvalid && m_tuser != ST_TRADE, m_tdata == '0, "non-trade beat carries data")
	`LOBM_ASSERT_NOW(a_trade_cross, m_tvalid && m_tuser == ST_TRADE, m_tdata[223:192] == m_tdata[191:160] && m_tdata[159:128] >= m_tdata[191:160], "trade without cross at ask price")

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
